/* sv/gtb_pkg.sv */
package gtb_pkg;

   localparam int unsigned TABLE_COUNT = 6;
   localparam int unsigned TABLE_DEPTH = 16;
   localparam int unsigned NIBBLE_BITS = 4;
   localparam int unsigned BYTE_BITS   = 8;
   localparam int unsigned SYM_BITS    = 16;
   localparam int unsigned ROW_BITS    = 3;

   localparam logic [SYM_BITS-1:0] SKIP_LOG = 16'hFFFF;

   // Request kinds carried on tuser.
   localparam logic REQ_BUTTERFLY   = 1'b0;
   localparam logic REQ_TABLE_WRITE = 1'b1;

   // Register indexes on the configuration port (byte address = 4 * index).
   localparam logic [1:0] REG_INVERSE_MODE    = 2'd0;
   localparam logic [1:0] REG_ACCUMULATE_MODE = 2'd1;
   localparam logic [1:0] REG_MULTIPLY_LOG    = 2'd2;

   typedef logic [SYM_BITS-1:0]      sym_type;
   typedef logic [BYTE_BITS-1:0]     byte_type;
   typedef logic [NIBBLE_BITS-1:0]   nibble_type;
   typedef logic [ROW_BITS-1:0]      row_type;

   // Operands held between the table read and the butterfly combine.
   typedef struct packed {
      sym_type a;
      sym_type b;
      sym_type u;
      sym_type v;
      logic    eob;
   } stage_type;

   // Tower-field product from the six looked-up bytes, in table order.
   function automatic sym_type tower_product(input byte_type t0, input byte_type t1,
                                             input byte_type t2, input byte_type t3,
                                             input byte_type t4, input byte_type t5);
      byte_type ac;
      byte_type bd;
      byte_type cross_sum;
      ac        = t0 ^ t1;
      bd        = t2 ^ t3;
      cross_sum = t4 ^ t5;
      return {cross_sum ^ ac, ac ^ bd};
   endfunction

endpackage

/* sv/gf16_tower_butterfly.sv */
// Channel   Direction  Beat contents
// --------  ---------  -----------------------------------------------------------
// req_*     in         tuser: kind (butterfly / table write); tlast: end of block;
//                      tdata: x, y, u, v symbols, table row, index, byte
// rsp_*     out        tdata: u_result, v_result; tlast: end of block
// csr_*     in/out     APB registers: inverse mode, accumulate mode, multiply log
//
// One beat is taken every cycle while req_tready is high. A butterfly beat reads the
// six 16-entry product tables in the cycle it is accepted; the registered table read
// feeds the middle stage, and the output register then shows its result. A table
// write beat updates one table entry in its accept cycle and gives no result.
// Reset (synchronous, active high) clears the pipeline valid flags and the
// configuration registers; the tables keep their contents and must be loaded before use.
// A stall on rsp holds the output register; the middle stage still drains into
// an empty output register, and req_tready drops only when both stages are full.
module gf16_tower_butterfly (
   input  logic         clock,
   input  logic         reset,
   // Input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // [15:0] x_symbol, [31:16] y_symbol, [47:32] u_symbol, [63:48] v_symbol,
   // [66:64] table_row, [70:67] table_index, [78:71] table_byte, [79] zero
   input  logic [79:0]  req_tdata,
   // [0] req_type
   input  logic         req_tuser,
   input  logic         req_tlast,
   // Result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] u_result, [31:16] v_result
   output logic [31:0]  rsp_tdata,
   output logic         rsp_tlast,
   // Configuration port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // Configuration registers.
   logic                inverse_ff;
   logic                accumulate_ff;
   gtb_pkg::sym_type    log_ff;
   logic                csr_wr;
   logic [1:0]          csr_index;

   // Input beat fields.
   gtb_pkg::sym_type    x_sym;
   gtb_pkg::sym_type    y_sym;
   gtb_pkg::sym_type    u_sym;
   gtb_pkg::sym_type    v_sym;
   gtb_pkg::row_type    wr_row;
   gtb_pkg::nibble_type wr_index;
   gtb_pkg::byte_type   wr_byte;

   logic                req_fire;
   logic                is_write;
   logic                rd_en;
   gtb_pkg::sym_type    b_pre;
   gtb_pkg::byte_type   mix;
   gtb_pkg::nibble_type rd_addr [gtb_pkg::TABLE_COUNT];
   gtb_pkg::byte_type   rd_ff   [gtb_pkg::TABLE_COUNT];

   // Pipeline control and payload.
   logic                s1_vld_ff;
   logic                s1_vld_in;
   gtb_pkg::stage_type  s1_ff;
   logic                out_vld_ff;
   logic                out_vld_in;
   logic                out_free;
   logic                s1_adv;
   gtb_pkg::sym_type    prod;
   gtb_pkg::sym_type    a_mid;
   gtb_pkg::sym_type    b_mid;
   gtb_pkg::sym_type    u_res_in;
   gtb_pkg::sym_type    v_res_in;
   gtb_pkg::sym_type    u_res_ff;
   gtb_pkg::sym_type    v_res_ff;
   logic                eob_ff;

   // ---------------------------------------------------------------------------
   // Configuration port. Writes complete in the access phase; pready is tied high.
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff    <= 1'b0;
         accumulate_ff <= 1'b0;
         log_ff        <= gtb_pkg::SKIP_LOG;
      end else if (csr_wr) begin
         unique case (csr_index)
            gtb_pkg::REG_INVERSE_MODE:    inverse_ff    <= csr_pwdata[0];
            gtb_pkg::REG_ACCUMULATE_MODE: accumulate_ff <= csr_pwdata[0];
            gtb_pkg::REG_MULTIPLY_LOG:    log_ff        <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         gtb_pkg::REG_INVERSE_MODE:    csr_prdata = {31'd0, inverse_ff};
         gtb_pkg::REG_ACCUMULATE_MODE: csr_prdata = {31'd0, accumulate_ff};
         gtb_pkg::REG_MULTIPLY_LOG:    csr_prdata = {16'd0, log_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Beat unpacking and handshake.
   // ---------------------------------------------------------------------------
   assign x_sym    = req_tdata[15:0];
   assign y_sym    = req_tdata[31:16];
   assign u_sym    = req_tdata[47:32];
   assign v_sym    = req_tdata[63:48];
   assign wr_row   = req_tdata[66:64];
   assign wr_index = req_tdata[70:67];
   assign wr_byte  = req_tdata[78:71];

   // The output register frees when it is empty or being taken this cycle; the
   // middle stage then moves forward and can accept a new beat.
   assign out_free   = ~out_vld_ff | rsp_tready;
   assign s1_adv     = s1_vld_ff & out_free;
   assign req_tready = ~s1_vld_ff | out_free;
   assign req_fire   = req_tvalid & req_tready;
   assign is_write   = (req_tuser == gtb_pkg::REQ_TABLE_WRITE);
   assign rd_en      = req_fire & ~is_write;

   // In inverse order the multiply operand is y ^ x, otherwise y alone. The
   // table addresses are the nibbles of its low byte, high byte and their xor.
   assign b_pre = inverse_ff ? (y_sym ^ x_sym) : y_sym;
   assign mix   = b_pre[7:0] ^ b_pre[15:8];

   always_comb begin
      rd_addr[0] = b_pre[3:0];
      rd_addr[1] = b_pre[7:4];
      rd_addr[2] = b_pre[11:8];
      rd_addr[3] = b_pre[15:12];
      rd_addr[4] = mix[3:0];
      rd_addr[5] = mix[7:4];
   end

   // ---------------------------------------------------------------------------
   // Product tables: six 16x8 memories, one write and one registered read each.
   // Only one beat enters per cycle, so a table write always lands before any
   // later butterfly reads it; no forwarding is needed. Rows six and seven
   // match no table and are dropped. The read data only changes when a
   // butterfly is accepted, so it holds while the middle stage is stalled.
   // ---------------------------------------------------------------------------
   for (genvar t = 0; t < gtb_pkg::TABLE_COUNT; t++) begin : g_table
      gtb_pkg::byte_type tbl_mem [gtb_pkg::TABLE_DEPTH];
      logic              wr_en;

      assign wr_en = req_fire & is_write & (wr_row == gtb_pkg::ROW_BITS'(t));

      always_ff @(posedge clock) begin
         if (wr_en) begin
            tbl_mem[wr_index] <= wr_byte;
         end
         if (rd_en) begin
            rd_ff[t] <= tbl_mem[rd_addr[t]];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Middle stage: operands wait here beside the table read data.
   // ---------------------------------------------------------------------------
   always_comb begin
      if (req_fire) begin
         s1_vld_in = ~is_write;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_ff <= '{a: x_sym, b: b_pre, u: u_sym, v: v_sym, eob: req_tlast};
      end
   end

   // ---------------------------------------------------------------------------
   // Butterfly combine into the output register.
   // ---------------------------------------------------------------------------
   assign prod = gtb_pkg::tower_product(rd_ff[0], rd_ff[1], rd_ff[2],
                                        rd_ff[3], rd_ff[4], rd_ff[5]);

   always_comb begin
      a_mid = (log_ff == gtb_pkg::SKIP_LOG) ? s1_ff.a : (s1_ff.a ^ prod);
      b_mid = inverse_ff ? s1_ff.b : (s1_ff.b ^ a_mid);
      u_res_in = accumulate_ff ? (a_mid ^ s1_ff.u) : a_mid;
      v_res_in = accumulate_ff ? (b_mid ^ s1_ff.v) : b_mid;
   end

   always_comb begin
      if (s1_adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         u_res_ff <= u_res_in;
         v_res_ff <= v_res_in;
         eob_ff   <= s1_ff.eob;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {v_res_ff, u_res_ff};
   assign rsp_tlast  = eob_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   // A table write never creates work in the middle stage.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && is_write |=> !s1_vld_ff)
      else $error("table write beat entered the butterfly pipeline");

   // Every accepted butterfly occupies the middle stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_vld_ff)
      else $error("accepted butterfly beat was lost");

   // While the middle stage is stalled, its table read data must not move.
   assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_adv |=> $stable(rd_ff[0]) && $stable(rd_ff[5]))
      else $error("table read data changed under a stalled stage");

   // The input only backs off when both pipeline stages are full.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_vld_ff && out_vld_ff)
      else $error("input stalled with a free pipeline stage");

endmodule
